// ===== src/length_checksum_frame_receiver_unit_assert.svh =====
// Assertion macros for the frame receiver.
`ifndef LENGTH_CHECKSUM_FRAME_RECEIVER_UNIT_ASSERT_SVH
`define LENGTH_CHECKSUM_FRAME_RECEIVER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define LCFR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("frame receiver assertion failed");
`define LCFR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("frame receiver assertion failed");
`else
`define LCFR_ASSERT_IMP(lbl, ante, cons)
`define LCFR_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== src/lcfr_pkg.sv =====
package lcfr_pkg;

  localparam int BUF_DEPTH_DEF = 32;
  localparam int MAX_RESULTS   = 29;
  localparam int JOBQ_DEPTH    = 2;
  localparam int CNT_W         = 7;
  localparam int N_W           = $clog2(MAX_RESULTS + 1);

  localparam logic [CNT_W-1:0] COUNT_MAX = 7'd127;
  localparam logic [CNT_W-1:0] HDR_POS   = 7'd3;
  localparam logic [N_W-1:0]   MAX_RES_N = N_W'(MAX_RESULTS);
  localparam logic [7:0]       MAX_RES_B = 8'(MAX_RESULTS);

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_TOO_BIG   = 3'd1;
  localparam logic [2:0] ST_LEN_MISM  = 3'd2;
  localparam logic [2:0] ST_TOO_SMALL = 3'd3;
  localparam logic [2:0] ST_CSUM_BAD  = 3'd4;

  localparam logic       REG_MAX_PAYLOAD = 1'b0;
  localparam logic [7:0] MAX_PAYLOAD_RST = 8'd29;

  typedef struct packed {
    logic [2:0]     status;
    logic [7:0]     command;
    logic [N_W-1:0] count;
  } job_t;

endpackage

// ===== src/lcfr_front.sv =====
module lcfr_front #(
  parameter int BUF_DEPTH = lcfr_pkg::BUF_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [7:0]                   in_tdata,   // [7:0] rx_byte
  input  logic                         in_tlast,
  input  logic [7:0]                   max_payload,
  output logic                         push,
  output lcfr_pkg::job_t               push_job,
  input  logic                         q_full,
  input  logic                         mem_done,
  input  logic                         rd_en,
  input  logic [$clog2(BUF_DEPTH)-1:0] rd_addr,
  output logic [7:0]                   rd_data
);

  localparam int AW = $clog2(BUF_DEPTH);
  localparam int CW = lcfr_pkg::CNT_W;
  localparam int NW = lcfr_pkg::N_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(BUF_DEPTH);

  logic [7:0]    mem [0:BUF_DEPTH-1];
  logic [7:0]    rd_data_r;
  logic [CW-1:0] cnt_r, cnt_nxt, cnt_inc;
  logic [7:0]    sum_r, sum_nxt;
  logic [7:0]    lo_r, lo_nxt, hi_r, hi_nxt, cmd_r, cmd_nxt;
  logic          busy_r, busy_nxt;
  logic          accept;
  logic [7:0]    lo_e, hi_e, cmd_e, lo_m1;
  logic [8:0]    len_p3;
  logic [2:0]    status;
  logic [NW-1:0] n_res;

  assign in_tready = !busy_r && !q_full;
  assign accept    = in_tvalid && in_tready;
  assign cnt_inc   = (cnt_r == lcfr_pkg::COUNT_MAX) ? cnt_r : cnt_r + 7'd1;

  assign lo_e   = (cnt_r == 7'd0) ? in_tdata : lo_r;
  assign hi_e   = (cnt_r == 7'd1) ? in_tdata : hi_r;
  assign cmd_e  = (cnt_r == 7'd2) ? in_tdata : cmd_r;
  assign len_p3 = {1'b0, lo_e} + 9'd3;
  assign lo_m1  = lo_e - 8'd1;

  always_comb begin
    if (hi_e != 8'd0 || lo_e > max_payload) begin
      status = lcfr_pkg::ST_TOO_BIG;
    end else if ({2'b00, cnt_inc} != len_p3) begin
      status = lcfr_pkg::ST_LEN_MISM;
    end else if (lo_e == 8'd0) begin
      status = lcfr_pkg::ST_TOO_SMALL;
    end else if (in_tdata != sum_r) begin
      status = lcfr_pkg::ST_CSUM_BAD;
    end else begin
      status = lcfr_pkg::ST_OK;
    end
    n_res = (lo_m1 > lcfr_pkg::MAX_RES_B) ? lcfr_pkg::MAX_RES_N : lo_m1[NW-1:0];
  end

  assign push             = accept && in_tlast;
  assign push_job.status  = status;
  assign push_job.command = (status == lcfr_pkg::ST_OK) ? cmd_e : 8'd0;
  assign push_job.count   = (status == lcfr_pkg::ST_OK) ? n_res : '0;

  always_comb begin
    cnt_nxt  = cnt_r;
    sum_nxt  = sum_r;
    lo_nxt   = lo_r;
    hi_nxt   = hi_r;
    cmd_nxt  = cmd_r;
    busy_nxt = busy_r;
    if (mem_done) begin
      busy_nxt = 1'b0;
    end
    if (accept) begin
      if (in_tlast) begin
        cnt_nxt = '0;
        sum_nxt = 8'd0;
        lo_nxt  = 8'd0;
        hi_nxt  = 8'd0;
        cmd_nxt = 8'd0;
        if (status == lcfr_pkg::ST_OK && n_res != '0) begin
          busy_nxt = 1'b1;
        end
      end else begin
        cnt_nxt = cnt_inc;
        sum_nxt = sum_r + in_tdata;
        lo_nxt  = lo_e;
        hi_nxt  = hi_e;
        cmd_nxt = cmd_e;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      sum_r  <= 8'd0;
      lo_r   <= 8'd0;
      hi_r   <= 8'd0;
      cmd_r  <= 8'd0;
      busy_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      sum_r  <= sum_nxt;
      lo_r   <= lo_nxt;
      hi_r   <= hi_nxt;
      cmd_r  <= cmd_nxt;
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && cnt_r < DEPTH_C) begin
      mem[cnt_r[AW-1:0]] <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== src/lcfr_queue.sv =====
module lcfr_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  lcfr_pkg::job_t push_job,
  input  logic           pop,
  output logic           q_valid,
  output logic           q_full,
  output lcfr_pkg::job_t q_job
);

  localparam int DEPTH = lcfr_pkg::JOBQ_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FW    = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_P = PW'(DEPTH - 1);
  localparam logic [FW-1:0] FULL_C = FW'(DEPTH);

  lcfr_pkg::job_t slots [0:DEPTH-1];
  logic [PW-1:0]  wp_r, wp_nxt, rp_r, rp_nxt;
  logic [FW-1:0]  fill_r, fill_nxt;
  logic           do_push, do_pop;

  assign q_valid = fill_r != '0;
  assign q_full  = fill_r == FULL_C;
  assign q_job   = slots[rp_r];
  assign do_push = push && !q_full;
  assign do_pop  = pop && q_valid;

  always_comb begin
    wp_nxt   = wp_r;
    rp_nxt   = rp_r;
    fill_nxt = fill_r;
    if (do_push) begin
      wp_nxt = (wp_r == LAST_P) ? '0 : wp_r + 1'b1;
    end
    if (do_pop) begin
      rp_nxt = (rp_r == LAST_P) ? '0 : rp_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      rp_r   <= '0;
      fill_r <= '0;
    end else begin
      wp_r   <= wp_nxt;
      rp_r   <= rp_nxt;
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wp_r] <= push_job;
    end
  end

endmodule

// ===== src/lcfr_back.sv =====
`include "length_checksum_frame_receiver_unit_assert.svh"

module lcfr_back #(
  parameter int BUF_DEPTH = lcfr_pkg::BUF_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_valid,
  input  lcfr_pkg::job_t               q_job,
  output logic                         pop,
  output logic                         rd_en,
  output logic [$clog2(BUF_DEPTH)-1:0] rd_addr,
  input  logic [7:0]                   rd_data,
  output logic                         mem_done,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [15:0]                  out_tdata,  // [7:0] command, [15:8] data_byte
  output logic [3:0]                   out_tuser,  // [2:0] status, [3] data_valid
  output logic                         out_tlast
);

  localparam int AW = $clog2(BUF_DEPTH);
  localparam int CW = lcfr_pkg::CNT_W;
  localparam int NW = lcfr_pkg::N_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(BUF_DEPTH);
  localparam logic [NW-1:0] ONE_N   = NW'(1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]    state_r, state_nxt;
  logic [7:0]    cmd_r, cmd_nxt;
  logic [NW-1:0] n_r, n_nxt, idx_r, idx_nxt;
  logic          inr_r, inr_nxt;
  logic          ov_r, ov_nxt;
  logic [2:0]    ost_r, ost_nxt;
  logic [7:0]    ocmd_r, ocmd_nxt, odat_r, odat_nxt;
  logic          odv_r, odv_nxt, olast_r, olast_nxt;
  logic [CW-1:0] pos;
  logic          pos_ok, slot_free, load, ld_last;

  assign pos       = {{(CW-NW){1'b0}}, idx_r} + lcfr_pkg::HDR_POS;
  assign pos_ok    = pos < DEPTH_C;
  assign slot_free = !ov_r || out_tready;
  assign ld_last   = (idx_r + ONE_N) == n_r;
  assign rd_addr   = pos[AW-1:0];

  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    n_nxt     = n_r;
    idx_nxt   = idx_r;
    inr_nxt   = inr_r;
    ost_nxt   = ost_r;
    ocmd_nxt  = ocmd_r;
    odat_nxt  = odat_r;
    odv_nxt   = odv_r;
    olast_nxt = olast_r;
    pop       = 1'b0;
    rd_en     = 1'b0;
    load      = 1'b0;
    mem_done  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          if (q_job.count == '0) begin
            if (slot_free) begin
              pop       = 1'b1;
              load      = 1'b1;
              ost_nxt   = q_job.status;
              ocmd_nxt  = q_job.command;
              odat_nxt  = 8'd0;
              odv_nxt   = 1'b0;
              olast_nxt = 1'b1;
            end
          end else begin
            pop       = 1'b1;
            cmd_nxt   = q_job.command;
            n_nxt     = q_job.count;
            idx_nxt   = '0;
            state_nxt = ST_READ;
          end
        end
      end
      ST_READ: begin
        rd_en     = pos_ok;
        inr_nxt   = pos_ok;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (slot_free) begin
          load      = 1'b1;
          ost_nxt   = lcfr_pkg::ST_OK;
          ocmd_nxt  = cmd_r;
          odat_nxt  = inr_r ? rd_data : 8'd0;
          odv_nxt   = 1'b1;
          olast_nxt = ld_last;
          if (ld_last) begin
            mem_done  = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt   = idx_r + ONE_N;
            state_nxt = ST_READ;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    ov_nxt = load ? 1'b1 : (out_tready ? 1'b0 : ov_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r    <= 1'b0;
      idx_r   <= '0;
      n_r     <= '0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      idx_r   <= idx_nxt;
      n_r     <= n_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    inr_r   <= inr_nxt;
    ost_r   <= ost_nxt;
    ocmd_r  <= ocmd_nxt;
    odat_r  <= odat_nxt;
    odv_r   <= odv_nxt;
    olast_r <= olast_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {odat_r, ocmd_r};
  assign out_tuser  = {odv_r, ost_r};
  assign out_tlast  = olast_r;

  `LCFR_ASSERT_IMP(a_idx_below_n, state_r != ST_IDLE, idx_r < n_r)
  `LCFR_ASSERT_IMP(a_payload_ok, out_tvalid && out_tuser[3], out_tuser[2:0] == lcfr_pkg::ST_OK)
  `LCFR_ASSERT_IMP(a_done_on_last, mem_done, load && ld_last && state_r == ST_EMIT)
  `LCFR_ASSERT_NEXT(a_emit_holds, state_r == ST_EMIT && !slot_free, state_r == ST_EMIT && $stable(idx_r))

endmodule

// ===== src/length_checksum_frame_receiver_unit.sv =====
// Port group  Kind            Contents
// in_         stream slave    tdata[7:0] rx_byte, tlast end_of_write
// out_        stream master   tdata command/data_byte, tuser status/data_valid, tlast last
// cfg_        APB slave       max_payload at byte address 0
//
// One byte per cycle is taken while no frame with payload is being read out and the job queue is not full.
// After a good frame each payload word passes through a store read, then the output register.
// An error or command-only frame gives its single word straight from the job queue.
// in_tready drops while the frame store is being read out or the job queue is full.
// Reset is synchronous; the frame store is not cleared and needs no sweep.
module length_checksum_frame_receiver_unit #(
  parameter int BUF_DEPTH = lcfr_pkg::BUF_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] rx_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,   // [7:0] command, [15:8] data_byte
  output logic [3:0]  out_tuser,   // [2:0] status, [3] data_valid
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int AW = $clog2(BUF_DEPTH);

  logic [7:0]     max_r;
  logic           cfg_wr;
  logic           push, pop, q_valid, q_full, mem_done, rd_en;
  lcfr_pkg::job_t push_job, q_job;
  logic [AW-1:0]  rd_addr;
  logic [7:0]     rd_data;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (cfg_paddr[2] == lcfr_pkg::REG_MAX_PAYLOAD) ? {24'd0, max_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r <= lcfr_pkg::MAX_PAYLOAD_RST;
    end else if (cfg_wr && cfg_paddr[2] == lcfr_pkg::REG_MAX_PAYLOAD) begin
      max_r <= cfg_pwdata[7:0];
    end
  end

  lcfr_front #(.BUF_DEPTH(BUF_DEPTH)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .max_payload (max_r),
    .push        (push),
    .push_job    (push_job),
    .q_full      (q_full),
    .mem_done    (mem_done),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data)
  );

  lcfr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_full   (q_full),
    .q_job    (q_job)
  );

  lcfr_back #(.BUF_DEPTH(BUF_DEPTH)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_job      (q_job),
    .pop        (pop),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .mem_done   (mem_done),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
